[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers, empty in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ETR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ETR_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition");
`else
`define ETR_ASSERT(lbl, clk, rst_n, prop)
`define ETR_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

[src/etr_pkg.sv]
// ---------------------------------------------------------------------------
// etr_pkg
// Types and constants of the event trace ring buffer.
// ---------------------------------------------------------------------------
package etr_pkg;

  localparam int unsigned CODE_COUNT = 32;
  localparam logic [15:0] MS_LIMIT   = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_LOG    = 2'd0,
    KIND_START  = 2'd1,
    KIND_READ   = 2'd2,
    KIND_STATUS = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_CAPTURE_LEVEL = 2'd0,
    REG_RING_CAPACITY = 2'd1,
    REG_CODE_LEVELS   = 2'd2,
    REG_START_CODE    = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_BUSY = 1'b1
  } state_e;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         event_code;
    logic [7:0]         arg_a;
    logic signed [15:0] arg_b;
    logic [15:0]        boot_number;
    logic [31:0]        time_ms;
    logic [5:0]         read_index;
  } trace_req_t;

  typedef struct packed {
    logic               accepted;
    logic               entry_valid;
    logic [15:0]        entry_boot;
    logic [15:0]        entry_ms;
    logic [4:0]         entry_code;
    logic [7:0]         entry_a;
    logic signed [15:0] entry_b;
    logic [6:0]         entry_count;
    logic [31:0]        dropped_total;
  } trace_rsp_t;

  typedef struct packed {
    logic [15:0]        boot;
    logic [15:0]        ms;
    logic [4:0]         code;
    logic [7:0]         a;
    logic signed [15:0] b;
  } entry_t;

endpackage

[src/event_trace_ring_buffer_top.sv]
// ---------------------------------------------------------------------------
// event_trace_ring_buffer_top
// Event trace capture ring with overwrite of the oldest entry.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid_i/in_ready_o carrying a trace_req_t: log an
//   event, start capture (clear plus marker entry), read an entry by
//   chronological index, or query status. Each request returns exactly one
//   trace_rsp_t on out_valid_o/out_ready_i.
//   Configuration registers (capture level, ring capacity, code level table,
//   start code) are written on cfg_valid_i/cfg_ready_o; cfg_ready_o is always
//   high. The user must write them only while no request is in flight; the
//   block itself does not enforce this. An accepted request moves the FSM
//   to ST_BUSY, from which out_valid_o is registered in the next cycle.
//   A new request is taken only in ST_IDLE, never while ST_BUSY loads the
//   entry memory's registered read data into the response register.
//   The next request is taken while the response register drains in the
//   same cycle; a stalled receiver holds the response and blocks input.
//   Reset clears the pointers, counters and configuration at once; the
//   entry memory is not cleared, so after a ring capacity change a read
//   can return an entry that was never written.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module event_trace_ring_buffer_top #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  etr_pkg::trace_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output etr_pkg::trace_rsp_t out_rsp_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [63:0]       cfg_data_i
);

  localparam int unsigned PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
  localparam int unsigned CW    = (CNT_W > 7) ? CNT_W : 7;

  logic [1:0]  level_q;
  logic [6:0]  capacity_q;
  logic [63:0] code_levels_q;
  logic [4:0]  start_code_q;

  logic [PTR_W-1:0] wp_q, wp_d;
  logic [CNT_W-1:0] live_q, live_d;
  logic [31:0]      drop_q, drop_d;

  etr_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  etr_pkg::trace_rsp_t out_q;
  logic            rd_hit_q;
  etr_pkg::entry_t rd_data_q;

  etr_pkg::entry_t mem_q [RING_DEPTH];

  logic            in_fire;
  logic            is_log, is_start, is_read;
  logic [CW-1:0]   cap;
  logic [CW-1:0]   base_wp;
  logic [CW-1:0]   base_live;
  logic [31:0]     base_drop;
  logic [7:0]      st_code;
  logic [1:0]      code_lvl;
  logic            store_ok;
  logic [CW-1:0]   slot;
  logic [CW-1:0]   slot_inc;
  etr_pkg::entry_t wr_entry;
  logic            mem_we;
  logic [CW-1:0]   rd_n;
  logic [CW-1:0]   rd_h;
  logic [CW-1:0]   rd_idx;
  logic [CW:0]     rd_sum;
  logic [CW:0]     rd_phys;
  logic            rd_hit;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q       <= '0;
      capacity_q    <= '0;
      code_levels_q <= '0;
      start_code_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (etr_pkg::cfg_reg_e'(cfg_index_i))
        etr_pkg::REG_CAPTURE_LEVEL: level_q       <= cfg_data_i[1:0];
        etr_pkg::REG_RING_CAPACITY: capacity_q    <= cfg_data_i[6:0];
        etr_pkg::REG_CODE_LEVELS:   code_levels_q <= cfg_data_i;
        etr_pkg::REG_START_CODE:    start_code_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign in_fire  = in_valid_i && in_ready_o;
  assign is_log   = (in_req_i.kind == etr_pkg::KIND_LOG);
  assign is_start = (in_req_i.kind == etr_pkg::KIND_START);
  assign is_read  = (in_req_i.kind == etr_pkg::KIND_READ);

  always_comb begin
    if (capacity_q == 7'd0 || CW'(capacity_q) > CW'(RING_DEPTH)) begin
      cap = CW'(RING_DEPTH);
    end else begin
      cap = CW'(capacity_q);
    end
  end

  always_comb begin
    if (is_start) begin
      base_wp   = '0;
      base_live = '0;
      base_drop = '0;
      st_code   = {3'd0, start_code_q};
    end else begin
      base_wp   = CW'(wp_q);
      base_live = CW'(live_q);
      base_drop = drop_q;
      st_code   = in_req_i.event_code;
    end
    code_lvl = code_levels_q[{st_code[4:0], 1'b0} +: 2];
    store_ok = (is_log || is_start) && (level_q != 2'd0)
               && (st_code < 8'(etr_pkg::CODE_COUNT)) && (code_lvl <= level_q);
    slot     = (base_wp < cap) ? base_wp : '0;
    slot_inc = slot + CW'(1);

    wr_entry.boot = in_req_i.boot_number;
    wr_entry.ms   = (in_req_i.time_ms > 32'(etr_pkg::MS_LIMIT)) ? etr_pkg::MS_LIMIT
                                                               : in_req_i.time_ms[15:0];
    wr_entry.code = st_code[4:0];
    if (is_start) begin
      wr_entry.a = {6'd0, level_q};
      wr_entry.b = 16'(cap);
    end else begin
      wr_entry.a = in_req_i.arg_a;
      wr_entry.b = in_req_i.arg_b;
    end

    wp_d   = PTR_W'(base_wp);
    live_d = CNT_W'(base_live);
    drop_d = base_drop;
    if (store_ok) begin
      wp_d = (slot_inc >= cap) ? '0 : PTR_W'(slot_inc);
      if (base_live < cap) begin
        live_d = CNT_W'(base_live + CW'(1));
      end else begin
        live_d = CNT_W'(cap);
        drop_d = base_drop + 32'd1;
      end
    end
  end

  assign mem_we = in_fire && store_ok;

  always_comb begin
    rd_n    = (CW'(live_q) < cap) ? CW'(live_q) : cap;
    rd_h    = (CW'(wp_q) < cap) ? CW'(wp_q) : '0;
    rd_idx  = CW'(in_req_i.read_index);
    rd_sum  = {1'b0, rd_h} + {1'b0, cap} - {1'b0, rd_n} + {1'b0, rd_idx};
    rd_phys = (rd_sum >= {1'b0, cap}) ? (rd_sum - {1'b0, cap}) : rd_sum;
    rd_hit  = is_read && (rd_idx < rd_n);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[PTR_W'(slot)] <= wr_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && rd_hit) begin
      rd_data_q <= mem_q[PTR_W'(rd_phys)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      live_q   <= '0;
      drop_q   <= '0;
      rd_hit_q <= 1'b0;
    end else if (in_fire) begin
      if (is_log || is_start) begin
        wp_q   <= wp_d;
        live_q <= live_d;
        drop_q <= drop_d;
      end
      rd_hit_q <= rd_hit;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      etr_pkg::ST_IDLE: if (in_fire) state_d = etr_pkg::ST_BUSY;
      etr_pkg::ST_BUSY: state_d = etr_pkg::ST_IDLE;
      default:          state_d = etr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == etr_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
    out_valid_d = out_valid_q;
    unique case (state_q)
      etr_pkg::ST_BUSY: out_valid_d = 1'b1;
      etr_pkg::ST_IDLE: if (out_ready_i) out_valid_d = 1'b0;
      default:          out_valid_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= etr_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q.accepted      <= store_ok;
      out_q.entry_valid   <= rd_hit;
      if (is_log || is_start) begin
        out_q.entry_count   <= 7'(live_d);
        out_q.dropped_total <= drop_d;
      end else begin
        out_q.entry_count   <= 7'(live_q);
        out_q.dropped_total <= drop_q;
      end
    end
    if (state_q == etr_pkg::ST_BUSY) begin
      if (rd_hit_q) begin
        out_q.entry_boot <= rd_data_q.boot;
        out_q.entry_ms   <= rd_data_q.ms;
        out_q.entry_code <= rd_data_q.code;
        out_q.entry_a    <= rd_data_q.a;
        out_q.entry_b    <= rd_data_q.b;
      end else begin
        out_q.entry_boot <= '0;
        out_q.entry_ms   <= '0;
        out_q.entry_code <= '0;
        out_q.entry_a    <= '0;
        out_q.entry_b    <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `ETR_ASSERT(a_accept_busy, clk_i, rst_ni, in_fire |=> (state_q == etr_pkg::ST_BUSY))
  `ETR_ASSERT(a_busy_resp, clk_i, rst_ni, (state_q == etr_pkg::ST_BUSY) |=> out_valid_o)
  `ETR_NEVER(a_live_bound, clk_i, rst_ni, CW'(live_q) > CW'(RING_DEPTH))
  `ETR_NEVER(a_read_no_store, clk_i, rst_ni,
             out_valid_o && out_rsp_o.entry_valid && out_rsp_o.accepted)

endmodule

[test/event_trace_ring_buffer_top_tb.sv]
// ----------------------------------------------------------------------------
// Event trace ring buffer testbench
// Drives trace requests (log, start, read, status) with random gaps and
// receiver stalls, predicts each response from an internal model of the
// ring and its registers, and checks every response field in order.
// Configuration moves through several capture levels, capacities, code
// level tables and marker codes between idle phases.
// ----------------------------------------------------------------------------
module event_trace_ring_buffer_top_tb;

  localparam int unsigned RING_DEPTH  = 64;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_ITEMS = 190;
  localparam logic [6:0]  PHASE_CAP [PHASES] = '{7'd1, 7'd64, 7'd5, 7'd0, 7'd127,
                                                  7'd3, 7'd40, 7'd65, 7'd2, 7'd64};
  localparam logic [1:0]  PHASE_LVL [4] = '{2'd3, 2'd1, 2'd2, 2'd0};

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  etr_pkg::trace_req_t in_req = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  etr_pkg::trace_rsp_t out_rsp;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  etr_pkg::cfg_reg_e cfg_index = etr_pkg::REG_CAPTURE_LEVEL;
  logic [63:0] cfg_data = '0;

  event_trace_ring_buffer_top #(.RING_DEPTH(RING_DEPTH)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  etr_pkg::entry_t ring_mem [RING_DEPTH];
  int unsigned ring_wr_ptr  = 0;
  int unsigned ring_live    = 0;
  logic [31:0] ring_dropped = '0;
  logic [1:0]  lvl_reg      = '0;
  logic [6:0]  cap_reg      = '0;
  logic [63:0] code_lvl_reg = '0;
  logic [4:0]  marker_code_reg = '0;

  etr_pkg::trace_req_t req_q [$];
  etr_pkg::trace_rsp_t rsp_due_q [$];
  int unsigned unsent       = 0;
  int unsigned send_gap     = 0;
  int unsigned rsp_gap      = 0;
  int unsigned hold_left    = 0;
  logic        hold_start   = 1'b0;
  logic        steady       = 1'b0;
  int unsigned sent_total   = 0;
  int unsigned rsp_total    = 0;
  int unsigned stored_total = 0;
  int unsigned hit_reads    = 0;
  int unsigned wrap_rsps    = 0;
  int unsigned failures     = 0;
  int unsigned cycle_count  = 0;

  function automatic int unsigned ring_span();
    if (cap_reg == 7'd0 || cap_reg > RING_DEPTH) return RING_DEPTH;
    return cap_reg;
  endfunction

  function automatic logic ring_store(logic [7:0] code, logic [7:0] a, logic [15:0] b,
                                      logic [15:0] boot, logic [31:0] ms);
    int unsigned span;
    int unsigned slot;
    span = ring_span();
    if (lvl_reg == 2'd0 || code >= etr_pkg::CODE_COUNT) return 1'b0;
    if (code_lvl_reg[2 * code[4:0] +: 2] > lvl_reg) return 1'b0;
    slot = (ring_wr_ptr < span) ? ring_wr_ptr : 0;
    ring_mem[slot].boot = boot;
    ring_mem[slot].ms   = (ms > 32'd65535) ? etr_pkg::MS_LIMIT : ms[15:0];
    ring_mem[slot].code = code[4:0];
    ring_mem[slot].a    = a;
    ring_mem[slot].b    = b;
    ring_wr_ptr = (slot + 1 >= span) ? 0 : slot + 1;
    if (ring_live < span) begin
      ring_live = ring_live + 1;
    end else begin
      ring_live    = span;
      ring_dropped = ring_dropped + 1;
    end
    return 1'b1;
  endfunction

  function automatic etr_pkg::trace_rsp_t predict_trace_rsp(etr_pkg::trace_req_t req);
    etr_pkg::trace_rsp_t rsp;
    int unsigned span;
    int unsigned n;
    int unsigned head;
    int unsigned phys;
    rsp  = '0;
    span = ring_span();
    case (req.kind)
      etr_pkg::KIND_LOG: begin
        rsp.accepted = ring_store(req.event_code, req.arg_a, req.arg_b,
                                  req.boot_number, req.time_ms);
      end
      etr_pkg::KIND_START: begin
        ring_wr_ptr  = 0;
        ring_live    = 0;
        ring_dropped = '0;
        if (lvl_reg != 2'd0)
          rsp.accepted = ring_store({3'b000, marker_code_reg}, {6'd0, lvl_reg}, span[15:0],
                                    req.boot_number, req.time_ms);
      end
      etr_pkg::KIND_READ: begin
        n    = (ring_live < span) ? ring_live : span;
        head = (ring_wr_ptr < span) ? ring_wr_ptr : 0;
        if (req.read_index < n) begin
          phys = head + span - n + req.read_index;
          if (phys >= span) phys = phys - span;
          rsp.entry_valid = 1'b1;
          rsp.entry_boot  = ring_mem[phys].boot;
          rsp.entry_ms    = ring_mem[phys].ms;
          rsp.entry_code  = ring_mem[phys].code;
          rsp.entry_a     = ring_mem[phys].a;
          rsp.entry_b     = ring_mem[phys].b;
        end
      end
      default: begin
      end
    endcase
    rsp.entry_count   = ring_live[6:0];
    rsp.dropped_total = ring_dropped;
    return rsp;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic etr_pkg::trace_req_t req_of(etr_pkg::kind_e kind, logic [7:0] code,
                                                 logic [7:0] a, logic [15:0] b,
                                                 logic [15:0] boot, logic [31:0] ms,
                                                 logic [5:0] idx);
    etr_pkg::trace_req_t r;
    r.kind        = kind;
    r.event_code  = code;
    r.arg_a       = a;
    r.arg_b       = b;
    r.boot_number = boot;
    r.time_ms     = ms;
    r.read_index  = idx;
    return r;
  endfunction

  function automatic etr_pkg::trace_req_t random_req();
    etr_pkg::trace_req_t r;
    int unsigned pick;
    pick = $urandom_range(0, 199);
    if (pick < 100) r.kind = etr_pkg::KIND_LOG;
    else if (pick < 102) r.kind = etr_pkg::KIND_START;
    else if (pick < 176) r.kind = etr_pkg::KIND_READ;
    else r.kind = etr_pkg::KIND_STATUS;
    r.event_code  = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 31)) : 8'($urandom);
    r.arg_a       = 8'($urandom);
    r.arg_b       = 16'($urandom);
    r.boot_number = 16'($urandom);
    r.time_ms     = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 70000);
    r.read_index  = ($urandom_range(0, 1) != 0) ? 6'($urandom_range(0, 7)) : 6'($urandom);
    return r;
  endfunction

  function automatic void queue_req(etr_pkg::trace_req_t r);
    req_q.push_back(r);
    unsent = unsent + 1;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      failures = failures + 1;
    end
  endfunction

  function automatic void check_rsp(etr_pkg::trace_rsp_t got);
    etr_pkg::trace_rsp_t want;
    if (rsp_due_q.size() == 0) begin
      $error("response with no request outstanding");
      failures = failures + 1;
      return;
    end
    want         = rsp_due_q.pop_front();
    rsp_total    = rsp_total + 1;
    stored_total = stored_total + want.accepted;
    hit_reads    = hit_reads + want.entry_valid;
    if (want.dropped_total != 0) wrap_rsps = wrap_rsps + 1;
    check_field("accepted", want.accepted, got.accepted);
    check_field("entry_valid", want.entry_valid, got.entry_valid);
    check_field("entry_boot", want.entry_boot, got.entry_boot);
    check_field("entry_ms", want.entry_ms, got.entry_ms);
    check_field("entry_code", want.entry_code, got.entry_code);
    check_field("entry_a", want.entry_a, got.entry_a);
    check_field("entry_b", want.entry_b, got.entry_b);
    check_field("entry_count", want.entry_count, got.entry_count);
    check_field("dropped_total", want.dropped_total, got.dropped_total);
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        rsp_due_q.push_back(predict_trace_rsp(in_req));
        unsent     = unsent - 1;
        sent_total = sent_total + 1;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (req_q.size() != 0) begin
          in_req   <= req_q.pop_front();
          in_valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_start) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_rsp(out_rsp);
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (rsp_gap != 0) begin
        rsp_gap   <= rsp_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        rsp_gap   <= pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(etr_pkg::cfg_reg_e idx, logic [63:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      etr_pkg::REG_CAPTURE_LEVEL: lvl_reg = value[1:0];
      etr_pkg::REG_RING_CAPACITY: cap_reg = value[6:0];
      etr_pkg::REG_CODE_LEVELS:   code_lvl_reg = value;
      etr_pkg::REG_START_CODE:    marker_code_reg = value[4:0];
      default: begin
      end
    endcase
  endtask

  task automatic wait_idle();
    while (unsent != 0 || rsp_due_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    etr_pkg::trace_req_t r;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: capture off, empty ring
    queue_req(req_of(etr_pkg::KIND_LOG, 8'd3, 8'h11, 16'h2222, 16'h0003, 32'd10, 6'd0));
    queue_req(req_of(etr_pkg::KIND_READ, 8'd0, 8'h00, 16'h0000, 16'h0000, 32'd0, 6'd0));
    queue_req(req_of(etr_pkg::KIND_STATUS, 8'd0, 8'h00, 16'h0000, 16'h0000, 32'd0, 6'd0));
    queue_req(req_of(etr_pkg::KIND_START, 8'd0, 8'h00, 16'h0000, 16'h0001, 32'd1, 6'd0));
    wait_idle();

    write_reg(etr_pkg::REG_CAPTURE_LEVEL, 64'd2);
    write_reg(etr_pkg::REG_RING_CAPACITY, 64'd0);
    write_reg(etr_pkg::REG_CODE_LEVELS, 64'h8000_0000_0000_C008);
    write_reg(etr_pkg::REG_START_CODE, 64'd31);
    queue_req(req_of(etr_pkg::KIND_START, 8'd0, 8'h00, 16'h0000, 16'h1234, 32'd100, 6'd0));
    queue_req(req_of(etr_pkg::KIND_LOG, 8'd0, 8'h00, 16'h8000, 16'h0000, 32'd0, 6'd0));
    queue_req(req_of(etr_pkg::KIND_LOG, 8'd31, 8'hFF, 16'h7FFF, 16'hFFFF, 32'd65535, 6'd0));
    queue_req(req_of(etr_pkg::KIND_LOG, 8'd1, 8'h5A, 16'h0001, 16'h0001, 32'd65536, 6'd0));
    queue_req(req_of(etr_pkg::KIND_LOG, 8'd2, 8'hA5, 16'hFFFF, 16'h0002, 32'hFFFF_FFFF,
                     6'd0));
    queue_req(req_of(etr_pkg::KIND_LOG, 8'd7, 8'h01, 16'h0007, 16'h0007, 32'd7, 6'd0));
    queue_req(req_of(etr_pkg::KIND_LOG, 8'd32, 8'h02, 16'h0020, 16'h0020, 32'd32, 6'd0));
    queue_req(req_of(etr_pkg::KIND_LOG, 8'd255, 8'h03, 16'h00FF, 16'h00FF, 32'd255, 6'd0));
    queue_req(req_of(etr_pkg::KIND_READ, 8'd0, 8'h00, 16'h0000, 16'h0000, 32'd0, 6'd0));
    queue_req(req_of(etr_pkg::KIND_READ, 8'd0, 8'h00, 16'h0000, 16'h0000, 32'd0, 6'd4));
    queue_req(req_of(etr_pkg::KIND_READ, 8'd0, 8'h00, 16'h0000, 16'h0000, 32'd0, 6'd5));
    queue_req(req_of(etr_pkg::KIND_READ, 8'd0, 8'h00, 16'h0000, 16'h0000, 32'd0, 6'd63));
    queue_req(req_of(etr_pkg::KIND_STATUS, 8'd0, 8'h00, 16'h0000, 16'h0000, 32'd0, 6'd0));
    wait_idle();

    write_reg(etr_pkg::REG_CAPTURE_LEVEL, 64'd0);
    queue_req(req_of(etr_pkg::KIND_LOG, 8'd0, 8'h44, 16'h4444, 16'h0044, 32'd44, 6'd0));
    queue_req(req_of(etr_pkg::KIND_START, 8'd0, 8'h00, 16'h0000, 16'h0055, 32'd55, 6'd0));
    queue_req(req_of(etr_pkg::KIND_READ, 8'd0, 8'h00, 16'h0000, 16'h0000, 32'd0, 6'd0));
    wait_idle();

    // fill every slot so later capacity changes never expose an unwritten entry
    write_reg(etr_pkg::REG_CAPTURE_LEVEL, 64'd3);
    for (int i = 0; i < 70; i++) begin
      r            = random_req();
      r.kind       = etr_pkg::KIND_LOG;
      r.event_code = 8'($urandom_range(0, 31));
      queue_req(r);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      steady <= (p == 6);
      write_reg(etr_pkg::REG_CAPTURE_LEVEL,
                (p < 4) ? 64'(PHASE_LVL[p]) : 64'($urandom_range(1, 3)));
      write_reg(etr_pkg::REG_RING_CAPACITY, 64'(PHASE_CAP[p]));
      if (p == 0) write_reg(etr_pkg::REG_CODE_LEVELS, 64'd0);
      else if (p == 2) write_reg(etr_pkg::REG_CODE_LEVELS, 64'hAAAA_AAAA_AAAA_AAAA);
      else if (p == 4) write_reg(etr_pkg::REG_CODE_LEVELS, 64'hFFFF_FFFF_FFFF_FFFF);
      else write_reg(etr_pkg::REG_CODE_LEVELS, {32'($urandom), 32'($urandom)});
      if (p == 0) write_reg(etr_pkg::REG_START_CODE, 64'd0);
      else if (p == 1) write_reg(etr_pkg::REG_START_CODE, 64'd31);
      else write_reg(etr_pkg::REG_START_CODE, 64'($urandom_range(0, 31)));
      if (p % 3 != 2) begin
        r      = random_req();
        r.kind = etr_pkg::KIND_START;
        queue_req(r);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) queue_req(random_req());
      if (p == 1) begin
        @(posedge clk_i);
        hold_start <= 1'b1;
        @(posedge clk_i);
        hold_start <= 1'b0;
      end
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("Checked %0d responses to %0d requests over %0d ring settings.",
             rsp_total, sent_total, PHASES + 3);
    $display("Entries stored: %0d, reads that hit an entry: %0d, responses after overwrite: %0d.",
             stored_total, hit_reads, wrap_rsps);
    if (failures == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/etr_pkg.sv
src/event_trace_ring_buffer_top.sv
test/event_trace_ring_buffer_top_tb.sv
